FILE: design/usdb_pkg.sv
`timescale 1ns / 1ps

package usdb_pkg;

	localparam int PhaseW = 5;

	typedef logic [PhaseW-1:0] phase_t;

	localparam phase_t PH_IDLE      = 5'd0;
	localparam phase_t PH_VEC_FIRST = 5'd1;
	localparam phase_t PH_VEC_LAST  = 5'd9;
	localparam phase_t PH_R12_A     = 5'd11;
	localparam phase_t PH_R6_LAST   = 5'd12;
	localparam phase_t PH_R8_FIRST  = 5'd13;
	localparam phase_t PH_R8_MID    = 5'd14;
	localparam phase_t PH_R8_LAST   = 5'd15;

	typedef enum logic [1:0] {
		CMD_REG     = 2'b00,
		CMD_ONESHOT = 2'b01,
		CMD_VEC     = 2'b10,
		CMD_NOP     = 2'b11
	} cmd_t;

	typedef enum logic [1:0] {
		ACK_NONE = 2'd0,
		ACK_VEC  = 2'd1,
		ACK_REG  = 2'd2
	} ack_t;

	localparam logic CH_REG = 1'b0;
	localparam logic CH_VEC = 1'b1;

	typedef struct packed {
		logic       spi_channel;
		logic       open_frame;
		logic [7:0] chunk_bits;
		logic [3:0] bit_count;
		logic       close_frame;
		logic [1:0] ack_code;
	} chunk_t;

endpackage

FILE: design/usdb_decode.sv
`timescale 1ns / 1ps

module usdb_decode (
	input  usdb_pkg::phase_t phase,
	input  logic [7:0]       rx_byte,
	output logic             emit,
	output usdb_pkg::chunk_t chunk,
	output usdb_pkg::phase_t phase_next
);

	import usdb_pkg::*;

	cmd_t cmd;

	assign cmd = cmd_t'(rx_byte[7:6]);

	always_comb begin
		emit       = 1'b0;
		chunk      = '0;
		phase_next = PH_IDLE;
		unique case (phase) inside
			PH_IDLE: begin
				unique case (cmd)
					CMD_REG: begin
						emit = 1'b1;
						chunk.spi_channel = CH_REG;
						chunk.open_frame  = 1'b1;
						chunk.chunk_bits  = {4'd0, rx_byte[3:0]};
						chunk.bit_count   = 4'd4;
						unique case (rx_byte[5:4])
							2'd0: phase_next = PH_R6_LAST;
							2'd1: phase_next = PH_R12_A;
							2'd2: phase_next = PH_R8_MID;
							default: phase_next = PH_R8_FIRST;
						endcase
					end
					CMD_ONESHOT: begin
						emit = 1'b1;
						chunk.spi_channel = CH_REG;
						chunk.open_frame  = 1'b1;
						chunk.chunk_bits  = {3'd0, rx_byte[4:0]};
						chunk.bit_count   = 4'd5;
						chunk.close_frame = 1'b1;
					end
					CMD_VEC: begin
						emit = 1'b1;
						chunk.spi_channel = CH_VEC;
						chunk.open_frame  = 1'b1;
						chunk.chunk_bits  = {6'd0, rx_byte[1:0]};
						chunk.bit_count   = 4'd2;
						phase_next = PH_VEC_FIRST;
					end
					default: begin
						emit = 1'b0;
					end
				endcase
			end
			[PH_VEC_FIRST:PH_VEC_LAST]: begin
				emit = 1'b1;
				chunk.spi_channel = CH_VEC;
				chunk.chunk_bits  = rx_byte;
				chunk.bit_count   = 4'd8;
				if (phase == PH_VEC_LAST) begin
					chunk.close_frame = 1'b1;
					chunk.ack_code    = ACK_VEC;
				end else begin
					phase_next = phase + PhaseW'(1);
				end
			end
			PH_R12_A, PH_R6_LAST: begin
				emit = 1'b1;
				chunk.spi_channel = CH_REG;
				chunk.chunk_bits  = {2'd0, rx_byte[5:0]};
				chunk.bit_count   = 4'd6;
				if (phase == PH_R6_LAST) begin
					chunk.close_frame = 1'b1;
					chunk.ack_code    = ACK_REG;
				end else begin
					phase_next = PH_R6_LAST;
				end
			end
			[PH_R8_FIRST:PH_R8_LAST]: begin
				emit = 1'b1;
				chunk.spi_channel = CH_REG;
				chunk.chunk_bits  = rx_byte;
				chunk.bit_count   = 4'd8;
				if (phase == PH_R8_LAST) begin
					chunk.close_frame = 1'b1;
					chunk.ack_code    = ACK_REG;
				end else begin
					phase_next = phase + PhaseW'(1);
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

endmodule

FILE: design/uart_to_dual_spi_command_bridge.sv
`timescale 1ns / 1ps

// Converts UART command bytes into SPI chunks for a register channel and a
// vector channel. Each input beat carries one received byte on rx_byte with
// in_valid and in_stall. Each output beat carries one chunk: the channel, the
// frame open and close marks, up to eight bits right aligned and sent MSB
// first, the number of valid bits, and an acknowledge code on the last chunk
// of a stream. No-op bytes produce no output beat.
// A byte accepted into the input register is decoded against the parse phase,
// and its chunk is loaded into the output register, which drives out_valid,
// once that register is free to take it.
// One byte can be accepted every cycle while in_stall is low; the parse
// phase is updated as each byte leaves the input register, so back-to-back
// bytes decode in order. When the receiver stalls, the output chunk holds,
// the waiting byte stays in the input register, and in_stall rises only
// when both are full. Reset returns the parser to idle, awaiting a command
// byte, and empties both registers.

module uart_to_dual_spi_command_bridge (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       spi_channel,
	output logic       open_frame,
	output logic [7:0] chunk_bits,
	output logic [3:0] bit_count,
	output logic       close_frame,
	output logic [1:0] ack_code
);

	import usdb_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	phase_t     phase_q;
	phase_t     phase_next;
	logic       emit;
	chunk_t     chunk;
	chunk_t     chunk_s2;
	logic       valid_s2;
	logic       out_free;
	logic       advance;
	logic       in_take;

	assign out_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	usdb_decode u_decode (
		.phase      (phase_q),
		.rx_byte    (byte_s1),
		.emit       (emit),
		.chunk      (chunk),
		.phase_next (phase_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			phase_q  <= PH_IDLE;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= emit;
				phase_q  <= phase_next;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= rx_byte;
		end
		if (advance) begin
			chunk_s2 <= chunk;
		end
	end

	assign out_valid   = valid_s2;
	assign spi_channel = chunk_s2.spi_channel;
	assign open_frame  = chunk_s2.open_frame;
	assign chunk_bits  = chunk_s2.chunk_bits;
	assign bit_count   = chunk_s2.bit_count;
	assign close_frame = chunk_s2.close_frame;
	assign ack_code    = chunk_s2.ack_code;

	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_VEC_LAST || (phase_q >= PH_R12_A && phase_q <= PH_R8_LAST))
		else $error("parse phase left the legal set");

	a_ack_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ack_code != ACK_NONE |-> close_frame)
		else $error("acknowledge without frame close");

	a_ack_channel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ack_code == ACK_VEC |-> spi_channel == CH_VEC)
		else $error("vector acknowledge on register channel");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled while pipeline has room");

	a_vec_stream_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && phase_q == PH_VEC_LAST |=> phase_q == PH_IDLE)
		else $error("vector stream did not return to idle");

endmodule

FILE: bench/uart_to_dual_spi_command_bridge_test.sv
`timescale 1ns / 1ps

module uart_to_dual_spi_command_bridge_test;

	import usdb_pkg::*;

	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PATTERN
	} stall_mode_t;

	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 6;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       spi_channel;
	logic       open_frame;
	logic [7:0] chunk_bits;
	logic [3:0] bit_count;
	logic       close_frame;
	logic [1:0] ack_code;

	phase_t      bridge_phase = PH_IDLE;
	chunk_t      pending_chunks[$];
	chunk_t      want_chunk;
	int          errors = 0;
	int          bytes_sent = 0;
	int          frames_sent = 0;
	int          chunks_checked = 0;
	int          burst_left = 0;
	bit          gaps_on = 1'b0;
	stall_mode_t stall_mode = STALL_NONE;
	bit          hold_go = 1'b0;
	int          hold_left = 0;
	int          stall_tick = 0;

	uart_to_dual_spi_command_bridge uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.spi_channel(spi_channel),
		.open_frame(open_frame),
		.chunk_bits(chunk_bits),
		.bit_count(bit_count),
		.close_frame(close_frame),
		.ack_code(ack_code)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d chunks still expected.", pending_chunks.size());
		$display("DONE: errors detected");
		$finish;
	end

	function automatic chunk_t make_chunk(input logic ch, input logic op,
			input logic [7:0] bits, input logic [3:0] cnt, input logic cl, input ack_t ack);
		chunk_t c;
		c.spi_channel = ch;
		c.open_frame = op;
		c.chunk_bits = bits;
		c.bit_count = cnt;
		c.close_frame = cl;
		c.ack_code = ack;
		return c;
	endfunction

	// Advances the parser copy by one byte and returns 1 when a chunk results.
	function automatic bit decode_byte(input logic [7:0] b, output chunk_t c);
		phase_t ph;
		ph = bridge_phase;
		c = '0;
		if (ph == PH_IDLE) begin
			case (cmd_t'(b[7:6]))
				CMD_REG: begin
					case (b[5:4])
						2'd0: bridge_phase = PH_R6_LAST;
						2'd1: bridge_phase = PH_R12_A;
						2'd2: bridge_phase = PH_R8_MID;
						default: bridge_phase = PH_R8_FIRST;
					endcase
					c = make_chunk(CH_REG, 1'b1, {4'h0, b[3:0]}, 4'd4, 1'b0, ACK_NONE);
					return 1'b1;
				end
				CMD_ONESHOT: begin
					c = make_chunk(CH_REG, 1'b1, {3'h0, b[4:0]}, 4'd5, 1'b1, ACK_NONE);
					return 1'b1;
				end
				CMD_VEC: begin
					bridge_phase = PH_VEC_FIRST;
					c = make_chunk(CH_VEC, 1'b1, {6'h00, b[1:0]}, 4'd2, 1'b0, ACK_NONE);
					return 1'b1;
				end
				default: return 1'b0;
			endcase
		end
		if (ph >= PH_VEC_FIRST && ph <= PH_VEC_LAST) begin
			if (ph == PH_VEC_LAST) begin
				bridge_phase = PH_IDLE;
				c = make_chunk(CH_VEC, 1'b0, b, 4'd8, 1'b1, ACK_VEC);
			end else begin
				bridge_phase = ph + PhaseW'(1);
				c = make_chunk(CH_VEC, 1'b0, b, 4'd8, 1'b0, ACK_NONE);
			end
			return 1'b1;
		end
		if (ph == PH_R12_A) begin
			bridge_phase = PH_R6_LAST;
			c = make_chunk(CH_REG, 1'b0, {2'b00, b[5:0]}, 4'd6, 1'b0, ACK_NONE);
			return 1'b1;
		end
		if (ph == PH_R6_LAST) begin
			bridge_phase = PH_IDLE;
			c = make_chunk(CH_REG, 1'b0, {2'b00, b[5:0]}, 4'd6, 1'b1, ACK_REG);
			return 1'b1;
		end
		if (ph >= PH_R8_FIRST && ph <= PH_R8_LAST) begin
			if (ph == PH_R8_LAST) begin
				bridge_phase = PH_IDLE;
				c = make_chunk(CH_REG, 1'b0, b, 4'd8, 1'b1, ACK_REG);
			end else begin
				bridge_phase = ph + PhaseW'(1);
				c = make_chunk(CH_REG, 1'b0, b, 4'd8, 1'b0, ACK_NONE);
			end
			return 1'b1;
		end
		bridge_phase = PH_IDLE;
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("Mismatch in %s at %0t: got %0d, expected %0d.", what, $time, got, want);
	endtask

	// Offers one byte and returns at the edge where it is accepted. The valid
	// stays high afterward so that the next byte can follow without a gap.
	task automatic send_byte(input logic [7:0] b);
		chunk_t c;
		int gap;
		if (gaps_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(1, 9);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		if (burst_left > 0)
			burst_left--;
		bytes_sent++;
		if (decode_byte(b, c))
			pending_chunks.push_back(c);
	endtask

	task automatic send_frame(input cmd_t kind);
		logic [7:0] head;
		int n_data;
		head = 8'($urandom_range(0, 255));
		head[7:6] = kind;
		n_data = 0;
		case (kind)
			CMD_REG: n_data = (head[5:4] == 2'd3) ? 3 : (head[5:4] == 2'd0) ? 1 : 2;
			CMD_VEC: n_data = 9;
			default: n_data = 0;
		endcase
		send_byte(head);
		repeat (n_data) send_byte(8'($urandom_range(0, 255)));
		frames_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_chunks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_traffic(input int n_bytes);
		int stop_at;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			if ($urandom_range(0, 99) < 85)
				send_frame(cmd_t'($urandom_range(0, 3)));
			else
				send_byte(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 60) == 0)
				wait_drained();
		end
	endtask

	task automatic test_directed();
		stall_mode = STALL_NONE;
		gaps_on = 1'b0;
		// Register frame with one 6-bit byte whose upper bits must be dropped.
		send_byte(8'h0F);
		send_byte(8'hFF);
		// Register frame with two 6-bit bytes.
		send_byte(8'h10);
		send_byte(8'hC0);
		send_byte(8'h3F);
		// Register frame with two 8-bit bytes.
		send_byte(8'h2A);
		send_byte(8'h00);
		send_byte(8'hFF);
		// Register frame with three 8-bit bytes.
		send_byte(8'h35);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(8'h01);
		// One-shot commands at both extremes.
		send_byte(8'h40);
		send_byte(8'h7F);
		// No-op gives no chunk.
		send_byte(8'hFF);
		// Full vector stream.
		send_byte(8'h83);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hA5);
		send_byte(8'h5A);
		send_byte(8'h80);
		send_byte(8'h01);
		send_byte(8'h7F);
		send_byte(8'hFE);
		send_byte(8'hC3);
		wait_drained();
	endtask

	task automatic test_full_rate();
		stall_mode = STALL_NONE;
		gaps_on = 1'b0;
		random_traffic(300);
		wait_drained();
	endtask

	task automatic test_random_stalls();
		stall_mode = STALL_RANDOM;
		gaps_on = 1'b1;
		random_traffic(600);
		wait_drained();
	endtask

	task automatic test_stall_pattern();
		stall_mode = STALL_PATTERN;
		gaps_on = 1'b1;
		random_traffic(500);
		wait_drained();
	endtask

	// The receiver holds off while bytes keep coming, so the block fills and
	// stalls its input until the hold ends.
	task automatic test_backpressure();
		stall_mode = STALL_NONE;
		gaps_on = 1'b0;
		hold_go = 1'b1;
		random_traffic(250);
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (hold_go) begin
			hold_left = HOLD_CYCLES;
			hold_go = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				STALL_RANDOM: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_PATTERN: begin
					stall_tick++;
					out_stall <= (stall_tick % 7) < 3;
				end
				default: out_stall <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_chunks.size() == 0) begin
				errors++;
				$display("Unexpected chunk at %0t: bits %0h, count %0d.", $time,
					chunk_bits, bit_count);
			end else begin
				want_chunk = pending_chunks.pop_front();
				chunks_checked++;
				if (spi_channel !== want_chunk.spi_channel)
					report_mismatch("spi_channel", spi_channel, want_chunk.spi_channel);
				if (open_frame !== want_chunk.open_frame)
					report_mismatch("open_frame", open_frame, want_chunk.open_frame);
				if (chunk_bits !== want_chunk.chunk_bits)
					report_mismatch("chunk_bits", chunk_bits, want_chunk.chunk_bits);
				if (bit_count !== want_chunk.bit_count)
					report_mismatch("bit_count", bit_count, want_chunk.bit_count);
				if (close_frame !== want_chunk.close_frame)
					report_mismatch("close_frame", close_frame, want_chunk.close_frame);
				if (ack_code !== want_chunk.ack_code)
					report_mismatch("ack_code", ack_code, want_chunk.ack_code);
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_rate();
		test_random_stalls();
		test_stall_pattern();
		test_backpressure();
		if (pending_chunks.size() != 0) begin
			errors++;
			$display("%0d expected chunks never arrived.", pending_chunks.size());
		end
		$display("Sent %0d bytes in %0d random frames plus directed cases; checked %0d chunks.",
			bytes_sent, frames_sent, chunks_checked);
		$display("Traffic ran at full rate, with random and patterned stalls, %s",
			"and under a long hold.");
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
